// ----- hdl/ddd_pkg.sv -----
// ----------------------------------------------------------------------------
// ddd_pkg
// Shared widths, constants, calendar tables and pipeline control type for the
// date day distance block.
// ----------------------------------------------------------------------------
package ddd_pkg;

  localparam int DAY_W      = 5;
  localparam int MONTH_W    = 4;
  localparam int YEAR_W     = 14;
  localparam int DIST_W     = 22;
  localparam int SERIAL_W   = 23;
  localparam int DAYS_W     = 10;

  localparam int unsigned MAX_YEAR_DEF = 9999;

  localparam int unsigned DAYS_PER_YEAR = 365;
  localparam int unsigned CENTURY       = 100;
  localparam int unsigned FEB_DAYS      = 28;
  localparam int unsigned FEBRUARY      = 2;
  localparam int unsigned MARCH         = 3;
  localparam int unsigned DECEMBER      = 12;

  // floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for every x below 2**14
  localparam int unsigned RECIP_100   = 5243;
  localparam int          RECIP_SHIFT = 19;
  localparam int          RECIP_W     = 13;
  localparam int          PROD_W      = YEAR_W + RECIP_W;
  localparam int          QUOT_W      = PROD_W - RECIP_SHIFT;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  localparam int DATE_STAGES = 4;
  localparam int STAGES      = DATE_STAGES + 1;

  typedef struct packed {
    logic [DATE_STAGES-1:0] load;
    logic                   dist_load;
  } ddd_ctrl_t;

  // Days of all months before month m in a common year.
  function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
    logic [8:0] r;
    case (m)
      4'd0, 4'd1: r = 9'd0;
      4'd2:       r = 9'd31;
      4'd3:       r = 9'd59;
      4'd4:       r = 9'd90;
      4'd5:       r = 9'd120;
      4'd6:       r = 9'd151;
      4'd7:       r = 9'd181;
      4'd8:       r = 9'd212;
      4'd9:       r = 9'd243;
      4'd10:      r = 9'd273;
      4'd11:      r = 9'd304;
      4'd12:      r = 9'd334;
      default:    r = 9'd365;
    endcase
    return r;
  endfunction

  // Length of month m in a common year; zero for a month code with no meaning.
  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] r;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   r = 5'd30;
      4'd2:                                      r = DAY_W'(FEB_DAYS);
      default:                                   r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- hdl/ddd_req_if.sv -----
// ----------------------------------------------------------------------------
// ddd_req_if
// Request channel: one beat carries two calendar dates.
// ----------------------------------------------------------------------------
interface ddd_req_if
  import ddd_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [DAY_W-1:0]   day_a;
  logic [MONTH_W-1:0] month_a;
  logic [YEAR_W-1:0]  year_a;
  logic [DAY_W-1:0]   day_b;
  logic [MONTH_W-1:0] month_b;
  logic [YEAR_W-1:0]  year_b;

  modport source (
    output valid, day_a, month_a, year_a, day_b, month_b, year_b,
    input  ready
  );

  modport sink (
    input  valid, day_a, month_a, year_a, day_b, month_b, year_b,
    output ready
  );
endinterface

// ----- hdl/ddd_rsp_if.sv -----
// ----------------------------------------------------------------------------
// ddd_rsp_if
// Response channel: one beat carries the day distance and two date flags.
// ----------------------------------------------------------------------------
interface ddd_rsp_if
  import ddd_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] distance_days;
  logic              valid_a;
  logic              valid_b;

  modport source (
    output valid, distance_days, valid_a, valid_b,
    input  ready
  );

  modport sink (
    input  valid, distance_days, valid_a, valid_b,
    output ready
  );
endinterface

// ----- hdl/ddd_pipe_ctrl.sv -----
// ----------------------------------------------------------------------------
// ddd_pipe_ctrl
// Valid bits and per-stage load enables; a stage loads when it is empty or
// the stage after it loads, so bubbles collapse under backpressure.
// ----------------------------------------------------------------------------
module ddd_pipe_ctrl
  import ddd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output ddd_ctrl_t ctrl
);

  logic [STAGES-1:0] v;
  logic [STAGES-1:0] rdy;

  always_comb begin
    rdy[STAGES-1] = !v[STAGES-1] || out_ready;
    for (int i = STAGES - 2; i >= 0; i--) begin
      rdy[i] = !v[i] || rdy[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) begin
        v[0] <= in_valid;
      end
      for (int i = 1; i < STAGES; i++) begin
        if (rdy[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  assign in_ready       = rdy[0];
  assign out_valid      = v[STAGES-1];
  assign ctrl.load      = rdy[DATE_STAGES-1:0];
  assign ctrl.dist_load = rdy[STAGES-1];

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> v[0])
    else $error("accepted beat did not enter first stage");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (v == {STAGES{1'b1}}))
    else $error("input stalled while a stage is empty");

  a_hold_out: assert property (@(posedge clk) disable iff (rst)
    (v[STAGES-1] && !out_ready) |=> v[STAGES-1])
    else $error("stalled result dropped");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (v == '0))
    else $error("pipeline not empty after reset");

endmodule

// ----- hdl/ddd_date_count.sv -----
// ----------------------------------------------------------------------------
// ddd_date_count
// Four-stage serial day count of one date: clamp and reciprocal products,
// year days and century product, leap and partial sums, final add.
// ----------------------------------------------------------------------------
module ddd_date_count
  import ddd_pkg::*;
#(
  parameter int unsigned MAX_YEAR = MAX_YEAR_DEF
) (
  input  logic                clk,
  input  ddd_ctrl_t           ctrl,
  input  logic [DAY_W-1:0]    day,
  input  logic [MONTH_W-1:0]  month,
  input  logic [YEAR_W-1:0]   year,
  output logic [SERIAL_W-1:0] serial,
  output logic                day_ok
);

  localparam logic [YEAR_W-1:0] MAX_YEAR_C = YEAR_W'(MAX_YEAR);

  logic [YEAR_W-1:0] year_c;
  logic [YEAR_W-1:0] n_c;

  logic [YEAR_W-1:0]  y1, n1;
  logic [MONTH_W-1:0] m1;
  logic [DAY_W-1:0]   d1;
  logic [PROD_W-1:0]  prod_n1, prod_y1;

  logic [YEAR_W-1:0]   y2, n2, qy100_2;
  logic [MONTH_W-1:0]  m2;
  logic [DAY_W-1:0]    d2, mlen2;
  logic [QUOT_W-1:0]   qn2, qy2;
  logic [SERIAL_W-1:0] n365_2;
  logic [8:0]          before2;

  logic leap2, leap_add2, feb2, ok2;

  logic [SERIAL_W-1:0] partial3;
  logic [DAYS_W-1:0]   days3;
  logic                ok3;

  always_comb begin
    if (year == '0) begin
      year_c = YEAR_W'(1);
    end else if (32'(year) > MAX_YEAR) begin
      year_c = MAX_YEAR_C;
    end else begin
      year_c = year;
    end
    n_c = year_c - YEAR_W'(1);
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[0]) begin
      y1      <= year_c;
      n1      <= n_c;
      m1      <= month;
      d1      <= day;
      prod_n1 <= PROD_W'(n_c) * PROD_W'(RECIP_100);
      prod_y1 <= PROD_W'(year_c) * PROD_W'(RECIP_100);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[1]) begin
      y2      <= y1;
      n2      <= n1;
      m2      <= m1;
      d2      <= d1;
      qn2     <= prod_n1[PROD_W-1:RECIP_SHIFT];
      qy2     <= prod_y1[PROD_W-1:RECIP_SHIFT];
      qy100_2 <= YEAR_W'(prod_y1[PROD_W-1:RECIP_SHIFT]) * YEAR_W'(CENTURY);
      n365_2  <= SERIAL_W'(n1) * SERIAL_W'(DAYS_PER_YEAR);
      before2 <= days_before(m1);
      mlen2   <= month_days(m1);
    end
  end

  always_comb begin
    leap2     = ((y2[1:0] == 2'b00) && (y2 != qy100_2)) ||
                ((y2 == qy100_2) && (qy2[1:0] == 2'b00));
    leap_add2 = leap2 && (m2 >= MONTH_W'(MARCH));
    feb2      = (m2 == MONTH_W'(FEBRUARY));
    ok2       = (m2 inside {[1:DECEMBER]}) && (d2 != '0) &&
                ({1'b0, d2} <= ({1'b0, mlen2} + 6'(leap2 && feb2)));
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[2]) begin
      partial3 <= n365_2 + SERIAL_W'(n2 >> 2) - SERIAL_W'(qn2) + SERIAL_W'(qn2 >> 2);
      days3    <= DAYS_W'(before2) + DAYS_W'(leap_add2) + DAYS_W'(d2);
      ok3      <= ok2;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[3]) begin
      serial <= partial3 + SERIAL_W'(days3);
      day_ok <= ok3;
    end
  end

endmodule

// ----- hdl/ddd_distance.sv -----
// ----------------------------------------------------------------------------
// ddd_distance
// Output stage: absolute difference of two serial counts, saturated to the
// result width, held with the date flags until taken.
// ----------------------------------------------------------------------------
module ddd_distance
  import ddd_pkg::*;
(
  input  logic                clk,
  input  ddd_ctrl_t           ctrl,
  input  logic [SERIAL_W-1:0] serial_a,
  input  logic [SERIAL_W-1:0] serial_b,
  input  logic                ok_a,
  input  logic                ok_b,
  output logic [DIST_W-1:0]   distance_days,
  output logic                valid_a,
  output logic                valid_b
);

  logic [SERIAL_W-1:0] diff;
  logic [DIST_W-1:0]   dist_sat;

  always_comb begin
    diff     = (serial_a >= serial_b) ? (serial_a - serial_b) : (serial_b - serial_a);
    dist_sat = (diff > SERIAL_W'(DIST_MAX)) ? DIST_MAX : diff[DIST_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (ctrl.dist_load) begin
      distance_days <= dist_sat;
      valid_a       <= ok_a;
      valid_b       <= ok_b;
    end
  end

endmodule

// ----- hdl/date_day_distance_top.sv -----
// ----------------------------------------------------------------------------
// date_day_distance_top
// Absolute distance in days between two Gregorian dates.
//
// Usage:
//   req carries one beat per date pair (day, month, year for each date);
//   rsp returns one beat per request with distance_days and the flags
//   valid_a / valid_b (day lies within its month's length).
//   Years of zero are taken as 1 and years above MAX_YEAR as MAX_YEAR.
//   A request beat passes through five register stages, the four of the
//   day count and the output register; one beat is taken every cycle
//   while req.ready is high. When rsp is stalled the output register holds
//   its beat and earlier stages keep filling; req.ready drops only when all
//   five stages are full. A synchronous rst empties the pipeline; no beat
//   is in flight after it.
// ----------------------------------------------------------------------------
module date_day_distance_top
  import ddd_pkg::*;
#(
  parameter int unsigned MAX_YEAR = MAX_YEAR_DEF
) (
  input logic     clk,
  input logic     rst,
  ddd_req_if.sink req,
  ddd_rsp_if.source rsp
);

  ddd_ctrl_t           ctrl;
  logic [SERIAL_W-1:0] serial_a, serial_b;
  logic                ok_a, ok_b;

  ddd_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .ctrl      (ctrl)
  );

  ddd_date_count #(.MAX_YEAR(MAX_YEAR)) u_count_a (
    .clk    (clk),
    .ctrl   (ctrl),
    .day    (req.day_a),
    .month  (req.month_a),
    .year   (req.year_a),
    .serial (serial_a),
    .day_ok (ok_a)
  );

  ddd_date_count #(.MAX_YEAR(MAX_YEAR)) u_count_b (
    .clk    (clk),
    .ctrl   (ctrl),
    .day    (req.day_b),
    .month  (req.month_b),
    .year   (req.year_b),
    .serial (serial_b),
    .day_ok (ok_b)
  );

  ddd_distance u_dist (
    .clk           (clk),
    .ctrl          (ctrl),
    .serial_a      (serial_a),
    .serial_b      (serial_b),
    .ok_a          (ok_a),
    .ok_b          (ok_b),
    .distance_days (rsp.distance_days),
    .valid_a       (rsp.valid_a),
    .valid_b       (rsp.valid_b)
  );

endmodule

// ----- sim/ddd_distance_checker.sv -----
// ----------------------------------------------------------------------------
// ddd_distance_checker
// Watches the request and response channels of the date day distance block.
// For every request beat it works out the day distance between the two dates
// and both day flags from its own calendar arithmetic, queues that result,
// and compares each response beat field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module ddd_distance_checker
  import ddd_pkg::*;
#(
  parameter int unsigned MAX_YEAR = MAX_YEAR_DEF
) (
  input  logic clk,
  input  logic rst,
  ddd_req_if   req,
  ddd_rsp_if   rsp,
  output int   errors,
  output int   outstanding
);

  typedef struct packed {
    logic [DIST_W-1:0] days;
    logic              ok_a;
    logic              ok_b;
  } day_span_t;

  localparam int unsigned CAL_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  day_span_t span_q[$];
  int        err_cnt = 0;
  int        open_cnt = 0;

  assign errors      = err_cnt;
  assign outstanding = open_cnt;

  function automatic bit leap_year(input int unsigned y);
    return ((y % 4 == 0) && (y % CENTURY != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned days_in(input int unsigned m, input int unsigned y);
    if (m == FEBRUARY) begin
      return FEB_DAYS + (leap_year(y) ? 1 : 0);
    end
    return CAL_DAYS[(m - 1) % DECEMBER];
  endfunction

  function automatic int unsigned serial_of(input logic [DAY_W-1:0]   d,
                                            input logic [MONTH_W-1:0] m,
                                            input logic [YEAR_W-1:0]  yr,
                                            output logic              ok);
    int unsigned y;
    int unsigned n;
    int unsigned mm;
    int unsigned dd;
    int unsigned prior;
    int unsigned total;
    int unsigned i;
    dd = d;
    mm = m;
    y  = yr;
    if (y == 0) begin
      y = 1;
    end else if (y > MAX_YEAR) begin
      y = MAX_YEAR;
    end
    n     = y - 1;
    total = DAYS_PER_YEAR * n + n / 4 - n / CENTURY + n / 400;
    prior = (mm == 0) ? 0 : ((mm - 1 > DECEMBER) ? DECEMBER : mm - 1);
    for (i = 1; i <= prior; i++) begin
      total += days_in(i, y);
    end
    total += dd;
    ok = (mm >= 1) && (mm <= DECEMBER) && (dd >= 1) && (dd <= days_in(mm, y));
    return total;
  endfunction

  function automatic day_span_t span_of(input logic [DAY_W-1:0]   da,
                                        input logic [MONTH_W-1:0] ma,
                                        input logic [YEAR_W-1:0]  ya,
                                        input logic [DAY_W-1:0]   db,
                                        input logic [MONTH_W-1:0] mb,
                                        input logic [YEAR_W-1:0]  yb);
    day_span_t   r;
    int unsigned sa;
    int unsigned sb;
    int unsigned diff;
    logic        oka;
    logic        okb;
    sa   = serial_of(da, ma, ya, oka);
    sb   = serial_of(db, mb, yb, okb);
    diff = (sa >= sb) ? sa - sb : sb - sa;
    if (diff > DIST_MAX) begin
      diff = DIST_MAX;
    end
    r.days = diff[DIST_W-1:0];
    r.ok_a = oka;
    r.ok_b = okb;
    return r;
  endfunction

  always @(posedge clk) begin
    day_span_t want;
    if (rst) begin
      span_q.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (span_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10) begin
            $display("unexpected result beat: dist=%0d va=%0b vb=%0b",
                     rsp.distance_days, rsp.valid_a, rsp.valid_b);
          end
        end else begin
          want = span_q.pop_front();
          if (rsp.distance_days !== want.days || rsp.valid_a !== want.ok_a ||
              rsp.valid_b !== want.ok_b) begin
            err_cnt++;
            if (err_cnt <= 10) begin
              $display("mismatch: want dist=%0d va=%0b vb=%0b, got dist=%0d va=%0b vb=%0b",
                       want.days, want.ok_a, want.ok_b,
                       rsp.distance_days, rsp.valid_a, rsp.valid_b);
            end
          end
        end
      end
      if (req.valid && req.ready) begin
        span_q.push_back(span_of(req.day_a, req.month_a, req.year_a,
                                 req.day_b, req.month_b, req.year_b));
      end
    end
    open_cnt = span_q.size();
  end

endmodule

// ----- sim/tb_date_day_distance_top.sv -----
// ----------------------------------------------------------------------------
// tb_date_day_distance_top
// Drives date pairs into the date day distance block: a directed set of
// calendar corners, then random pairs, mostly real dates with some raw field
// values. Both sides idle at random and the response side holds off once for
// a long stretch so the pipeline fills. A checker beside the block predicts
// and compares every response beat.
// ----------------------------------------------------------------------------
module tb_date_day_distance_top;
  import ddd_pkg::*;

  localparam int RANDOM_PAIRS = 1800;
  localparam int IDLE_MAX     = 16;
  localparam int HOLD_AT      = 400;
  localparam int HOLD_OFF     = 300;
  localparam int WATCHDOG     = 2000;
  localparam int DRAIN        = STAGES * 4;

  typedef struct {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
  } cal_date_t;

  localparam int CORNER_YEARS [12] = '{0, 1, 2, 399, 400, 1600, 1900, 2000, 9998, 9999,
                                       10000, 16383};

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   mismatch_cnt;
  int   open_cnt;
  int   pairs_sent = 0;
  int   beats_back = 0;

  ddd_req_if req ();
  ddd_rsp_if rsp ();

  date_day_distance_top u_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  ddd_distance_checker u_chk (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .rsp         (rsp),
    .errors      (mismatch_cnt),
    .outstanding (open_cnt)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic cal_date_t dt(input int d, input int m, input int y);
    cal_date_t r;
    r.day   = DAY_W'(d);
    r.month = MONTH_W'(m);
    r.year  = YEAR_W'(y);
    return r;
  endfunction

  function automatic cal_date_t pick_date();
    cal_date_t r;
    int        sel;
    sel     = $urandom_range(0, 99);
    r.month = MONTH_W'($urandom_range(1, 12));
    r.day   = ($urandom_range(0, 9) < 8) ? DAY_W'($urandom_range(1, 28))
                                          : DAY_W'($urandom_range(29, 31));
    if (sel < 65) begin
      r.year = YEAR_W'($urandom_range(1, MAX_YEAR_DEF));
    end else if (sel < 80) begin
      r.year = YEAR_W'(CORNER_YEARS[$urandom_range(0, 11)]);
    end else begin
      r.day   = DAY_W'($urandom);
      r.month = MONTH_W'($urandom);
      r.year  = YEAR_W'($urandom);
    end
    return r;
  endfunction

  task automatic offer_pair(input cal_date_t a, input cal_date_t b);
    int gap;
    gap = (((pairs_sent / 50) % 5) == 4) ? 0 : $urandom_range(0, IDLE_MAX);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid   <= 1'b1;
    req.day_a   <= a.day;
    req.month_a <= a.month;
    req.year_a  <= a.year;
    req.day_b   <= b.day;
    req.month_b <= b.month;
    req.year_b  <= b.year;
    @(negedge clk);
    while (!req.ready) @(negedge clk);
    @(posedge clk);
    pairs_sent++;
  endtask

  initial begin : stimulus
    cal_date_t a;
    cal_date_t b;
    req.valid   = 1'b0;
    req.day_a   = '0;
    req.month_a = '0;
    req.year_a  = '0;
    req.day_b   = '0;
    req.month_b = '0;
    req.year_b  = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    offer_pair(dt(1, 1, 1), dt(1, 1, 1));
    offer_pair(dt(1, 1, 1), dt(31, 12, 9999));
    offer_pair(dt(31, 12, 9999), dt(1, 1, 1));
    offer_pair(dt(1, 1, 0), dt(1, 1, 1));
    offer_pair(dt(31, 12, 16383), dt(31, 12, 9999));
    offer_pair(dt(15, 6, 10000), dt(1, 1, 2024));
    offer_pair(dt(5, 0, 2020), dt(5, 1, 2020));
    offer_pair(dt(1, 13, 2020), dt(1, 1, 2021));
    offer_pair(dt(31, 15, 16383), dt(0, 0, 0));
    offer_pair(dt(0, 3, 2021), dt(28, 2, 2021));
    offer_pair(dt(31, 4, 2021), dt(1, 5, 2021));
    offer_pair(dt(29, 2, 2000), dt(29, 2, 1900));
    offer_pair(dt(29, 2, 2004), dt(29, 2, 2001));
    offer_pair(dt(30, 2, 2024), dt(28, 2, 2023));
    offer_pair(dt(31, 12, 1999), dt(1, 1, 2000));
    offer_pair(dt(1, 3, 2400), dt(28, 2, 2100));
    offer_pair(dt(31, 1, 1), dt(30, 11, 9999));
    offer_pair(dt(16, 7, 1969), dt(20, 7, 1969));

    repeat (RANDOM_PAIRS) begin
      a = pick_date();
      if ($urandom_range(0, 3) == 0) begin
        b     = a;
        b.day = DAY_W'($urandom_range(0, 31));
      end else begin
        b = pick_date();
      end
      offer_pair(a, b);
    end
    req.valid <= 1'b0;

    @(negedge clk);
    while (open_cnt != 0) @(negedge clk);
    repeat (DRAIN) @(posedge clk);
    if (mismatch_cnt == 0 && open_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : response_side
    int stall;
    rsp.ready = 1'b0;
    forever begin
      if (beats_back == HOLD_AT) begin
        stall = HOLD_OFF;
      end else if (((beats_back / 60) % 4) == 3) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, IDLE_MAX);
      end
      if (stall > 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      @(negedge clk);
      while (!rsp.valid) @(negedge clk);
      @(posedge clk);
      beats_back++;
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG) begin
      @(posedge clk);
      if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("timeout: no beat for %0d cycles", WATCHDOG);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
